// ===== rtl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared widths, codes and control types of the segmented plate stack.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int INUSE_W  = 5;
  localparam int TOTAL_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_POP_AT = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // What the controller needs from the evaluation step.
  typedef enum logic [1:0] {
    ACT_FINISH = 2'd0,
    ACT_SCAN   = 2'd1,
    ACT_TAKE   = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EVAL  = 2'd1,
    S_FETCH = 2'd2
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic take;
    logic finish;
    logic fetch_done;
  } cmd_t;

  typedef struct packed {
    act_e act;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/sps_req_if.sv =====
// ----------------------------------------------------------------------------
// sps_req_if
// Request channel of the plate stack: valid, ready and the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_req_if;
  logic                               valid;
  logic                               ready;
  logic [sps_pkg::KIND_W-1:0]         kind;
  logic signed [sps_pkg::VALUE_W-1:0] push_value;
  logic [sps_pkg::INDEX_W-1:0]        stack_index;

  modport source (output valid, kind, push_value, stack_index, input ready);
  modport sink (input valid, kind, push_value, stack_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/sps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sps_rsp_if
// Result channel of the plate stack: valid, ready and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [sps_pkg::VALUE_W-1:0] popped_value;
  logic [sps_pkg::STATUS_W-1:0]       status;
  logic [sps_pkg::INUSE_W-1:0]        stacks_in_use;
  logic [sps_pkg::TOTAL_W-1:0]        total_plates;

  modport source (output valid, popped_value, status, stacks_in_use, total_plates,
                  input ready);
  modport sink (input valid, popped_value, status, stacks_in_use, total_plates,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/sps_datapath.sv =====
// ----------------------------------------------------------------------------
// sps_datapath
// Plate and fill count memories, occupancy counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_datapath #(
  parameter int PLATES_PER_STACK = 4,
  parameter int MAX_STACKS       = 16,
  parameter int VALUE_WIDTH      = 32
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire sps_pkg::cmd_t                      cmd_i,
  output sps_pkg::dp_status_t                     status_o,
  input  wire logic [sps_pkg::KIND_W-1:0]         req_kind_i,
  input  wire logic signed [sps_pkg::VALUE_W-1:0] req_value_i,
  input  wire logic [sps_pkg::INDEX_W-1:0]        req_index_i,
  output logic signed [sps_pkg::VALUE_W-1:0]      rsp_popped_o,
  output logic [sps_pkg::STATUS_W-1:0]            rsp_status_o,
  output logic [sps_pkg::INUSE_W-1:0]             rsp_inuse_o,
  output logic [sps_pkg::TOTAL_W-1:0]             rsp_total_o
);

  localparam int DEPTH = PLATES_PER_STACK * MAX_STACKS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(PLATES_PER_STACK + 1);
  localparam int OW    = $clog2(MAX_STACKS + 1);
  localparam int SW    = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int TW    = $clog2(DEPTH + 1);

  localparam logic [FW-1:0] PLATES_F = FW'(PLATES_PER_STACK);
  localparam logic [AW-1:0] PLATES_A = AW'(PLATES_PER_STACK);

  // Request latched at acceptance.
  sps_pkg::kind_e       kind_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [sps_pkg::INDEX_W-1:0] idx_q;

  logic [OW-1:0] open_q, open_d;
  logic [TW-1:0] total_q, total_d;

  logic [FW-1:0]          fill_mem [MAX_STACKS];
  logic [FW-1:0]          fill_rdata_q;
  logic [VALUE_WIDTH-1:0] plate_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] plate_rdata_q;

  logic signed [sps_pkg::VALUE_W-1:0] res_popped_q;
  logic [sps_pkg::STATUS_W-1:0]       res_status_q;
  logic [sps_pkg::INUSE_W-1:0]        res_inuse_q;
  logic [sps_pkg::TOTAL_W-1:0]        res_total_q;

  logic [OW-1:0]   open_m1, open_m2;
  logic [SW-1:0]   s_last;
  logic            open_zero, fill_zero, last_full, idx_bad;
  logic            push_new, push_ok;
  sps_pkg::status_e eval_status;
  sps_pkg::act_e    act;
  logic [SW-1:0]   take_s, push_s;
  logic [FW-1:0]   push_slot, fill_m1;
  logic [AW-1:0]   push_addr, take_addr;

  logic            fill_rd_en;
  logic [SW-1:0]   fill_rd_addr;
  logic            fill_we;
  logic [SW-1:0]   fill_wa;
  logic [FW-1:0]   fill_wd;

  assign open_m1   = open_q - OW'(1);
  assign open_m2   = open_q - OW'(2);
  assign s_last    = SW'(open_m1);
  assign open_zero = (open_q == '0);
  assign fill_zero = (fill_rdata_q == '0);
  assign last_full = (fill_rdata_q >= PLATES_F);
  assign idx_bad   = (32'(idx_q) >= 32'(open_q));
  assign fill_m1   = fill_rdata_q - FW'(1);

  // Decision of the evaluation step, taken on the fill count just read.
  always_comb begin
    eval_status = sps_pkg::ST_OK;
    act         = sps_pkg::ACT_FINISH;
    push_new    = 1'b0;
    take_s      = s_last;
    case (kind_q)
      sps_pkg::KIND_PUSH: begin
        if (open_zero || last_full) begin
          if (32'(open_q) >= 32'(MAX_STACKS)) begin
            eval_status = sps_pkg::ST_FULL;
          end else begin
            push_new = 1'b1;
          end
        end
      end
      sps_pkg::KIND_POP: begin
        if (open_zero) begin
          eval_status = sps_pkg::ST_EMPTY;
        end else if (fill_zero) begin
          act = sps_pkg::ACT_SCAN;
        end else begin
          act = sps_pkg::ACT_TAKE;
        end
      end
      sps_pkg::KIND_POP_AT: begin
        take_s = SW'(idx_q);
        if (idx_bad) begin
          eval_status = sps_pkg::ST_BAD_INDEX;
        end else if (fill_zero) begin
          eval_status = sps_pkg::ST_EMPTY;
        end else begin
          act = sps_pkg::ACT_TAKE;
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.act = act;

  assign push_ok   = (kind_q == sps_pkg::KIND_PUSH) && (eval_status == sps_pkg::ST_OK);
  assign push_s    = push_new ? SW'(open_q) : s_last;
  assign push_slot = push_new ? '0 : fill_rdata_q;
  assign push_addr = AW'(push_s) * PLATES_A + AW'(push_slot);
  assign take_addr = AW'(take_s) * PLATES_A + AW'(fill_m1);

  // Fill count memory port control.
  always_comb begin
    fill_rd_en   = 1'b0;
    fill_rd_addr = s_last;
    fill_we      = 1'b0;
    fill_wa      = push_s;
    fill_wd      = FW'(push_slot + FW'(1));
    if (cmd_i.load) begin
      fill_rd_en = 1'b1;
      if (sps_pkg::kind_e'(req_kind_i) == sps_pkg::KIND_POP_AT) begin
        fill_rd_addr = SW'(req_index_i);
      end
    end else if (cmd_i.scan) begin
      fill_rd_en   = 1'b1;
      fill_rd_addr = SW'(open_m2);
    end
    if (cmd_i.finish && push_ok) begin
      fill_we = 1'b1;
    end else if (cmd_i.take) begin
      fill_we = 1'b1;
      fill_wa = take_s;
      fill_wd = fill_m1;
    end
  end

  // Counter updates.
  always_comb begin
    open_d  = open_q;
    total_d = total_q;
    if (cmd_i.finish && push_ok) begin
      open_d  = open_q + OW'(push_new);
      total_d = total_q + TW'(1);
    end else if (cmd_i.scan) begin
      open_d = open_m1;
    end else if (cmd_i.take) begin
      total_d = total_q - TW'(1);
      // A plain pop closes the last substack when it runs dry.
      if (kind_q == sps_pkg::KIND_POP && fill_m1 == '0) begin
        open_d = open_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= '0;
      total_q <= '0;
    end else begin
      open_q  <= open_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_rd_en) begin
      fill_rdata_q <= fill_mem[fill_rd_addr];
    end
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      plate_rdata_q <= plate_mem[take_addr];
    end
    if (cmd_i.finish && push_ok) begin
      plate_mem[push_addr] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= sps_pkg::kind_e'(req_kind_i);
      value_q <= VALUE_WIDTH'($unsigned(req_value_i));
      idx_q   <= req_index_i;
    end
    if (cmd_i.finish) begin
      res_popped_q <= '0;
      res_status_q <= eval_status;
      res_inuse_q  <= sps_pkg::INUSE_W'(open_d);
      res_total_q  <= sps_pkg::TOTAL_W'(total_d);
    end else if (cmd_i.fetch_done) begin
      res_popped_q <= sps_pkg::VALUE_W'(plate_rdata_q);
      res_status_q <= sps_pkg::ST_OK;
      res_inuse_q  <= sps_pkg::INUSE_W'(open_q);
      res_total_q  <= sps_pkg::TOTAL_W'(total_q);
    end
  end

  assign rsp_popped_o = res_popped_q;
  assign rsp_status_o = res_status_q;
  assign rsp_inuse_o  = res_inuse_q;
  assign rsp_total_o  = res_total_q;

endmodule

`default_nettype wire

// ===== rtl/sps_controller.sv =====
// ----------------------------------------------------------------------------
// sps_controller
// Sequencer of the plate stack: accept, evaluate, fetch and hand over.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_controller (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  output logic                     rsp_valid_o,
  input  wire logic                rsp_ready_i,
  input  wire sps_pkg::dp_status_t status_i,
  output sps_pkg::cmd_t            cmd_o
);

  sps_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  // The result register may be refilled once it is empty or its result is taken.
  assign out_free    = !out_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == sps_pkg::S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      sps_pkg::S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sps_pkg::S_EVAL;
        end
      end
      sps_pkg::S_EVAL: begin
        case (status_i.act)
          sps_pkg::ACT_SCAN: begin
            cmd_o.scan = 1'b1;
          end
          sps_pkg::ACT_TAKE: begin
            cmd_o.take = 1'b1;
            state_d    = sps_pkg::S_FETCH;
          end
          sps_pkg::ACT_FINISH: begin
            if (out_free) begin
              cmd_o.finish = 1'b1;
              state_d      = sps_pkg::S_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      sps_pkg::S_FETCH: begin
        if (out_free) begin
          cmd_o.fetch_done = 1'b1;
          state_d          = sps_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sps_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish || cmd_o.fetch_done) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sps_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/segmented_plate_stack.sv =====
// ----------------------------------------------------------------------------
// segmented_plate_stack: fixed-size substacks used together as one stack.
// Steps: a request is accepted, evaluated on its registered fill count read and
// finished into the result register; a pop or pop-at that removes a value adds a
// registered plate fetch, and a pop first scans to close each trailing empty substack.
// A new request is taken only in idle; finish and fetch wait while a result is held.
// Reset clears counters and control at once; the memories keep their contents.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_plate_stack #(
  parameter int PLATES_PER_STACK = 4,
  parameter int MAX_STACKS       = 16,
  parameter int VALUE_WIDTH      = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sps_req_if.sink   req_i,
  sps_rsp_if.source rsp_o
);

  sps_pkg::cmd_t       cmd;
  sps_pkg::dp_status_t dp_status;

  sps_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  sps_datapath #(
    .PLATES_PER_STACK (PLATES_PER_STACK),
    .MAX_STACKS       (MAX_STACKS),
    .VALUE_WIDTH      (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .req_kind_i   (req_i.kind),
    .req_value_i  (req_i.push_value),
    .req_index_i  (req_i.stack_index),
    .rsp_popped_o (rsp_o.popped_value),
    .rsp_status_o (rsp_o.status),
    .rsp_inuse_o  (rsp_o.stacks_in_use),
    .rsp_total_o  (rsp_o.total_plates)
  );

endmodule

`default_nettype wire

// ===== tb/segmented_plate_stack_tb.sv =====
// ----------------------------------------------------------------------------
// segmented_plate_stack_tb
// Drives push, pop, pop-at and unused requests into the plate stack with
// random gaps and result stalls, predicts every result from its own copy of
// the substack state and checks each result field by field as it arrives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segmented_plate_stack_tb;

  localparam logic [sps_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } traffic_mode_e;

  typedef struct {
    logic [sps_pkg::KIND_W-1:0]  kind;
    logic [sps_pkg::VALUE_W-1:0] value;
    logic [sps_pkg::INDEX_W-1:0] idx;
  } plate_request_t;

  typedef struct packed {
    logic [sps_pkg::VALUE_W-1:0]  popped;
    logic [sps_pkg::STATUS_W-1:0] status;
    logic [sps_pkg::INUSE_W-1:0]  in_use;
    logic [sps_pkg::TOTAL_W-1:0]  total;
  } stack_result_t;

  class plate_scoreboard;
    localparam int PLATES = 4;
    localparam int STACKS = 16;

    logic [sps_pkg::VALUE_W-1:0] plates [PLATES*STACKS];
    int unsigned                 fill [STACKS];
    int unsigned                 open_cnt;
    int unsigned                 total;
    stack_result_t               expected_results [$];
    int unsigned                 errors;

    function new();
      foreach (fill[i]) fill[i] = 0;
      foreach (plates[i]) plates[i] = '0;
      open_cnt = 0;
      total    = 0;
      errors   = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function logic [sps_pkg::VALUE_W-1:0] take_top(int unsigned s);
      fill[s]--;
      total--;
      return plates[s*PLATES + fill[s]];
    endfunction

    // Advances the predicted substacks by one accepted request.
    function void note_request(plate_request_t rq);
      stack_result_t r;
      int unsigned   last;
      r        = '0;
      r.status = sps_pkg::ST_OK;
      case (rq.kind)
        sps_pkg::KIND_PUSH: begin
          if (open_cnt == 0 || fill[open_cnt-1] >= PLATES) begin
            if (open_cnt >= STACKS) begin
              r.status = sps_pkg::ST_FULL;
            end else begin
              fill[open_cnt] = 0;
              open_cnt++;
            end
          end
          if (r.status == sps_pkg::ST_OK) begin
            last = open_cnt - 1;
            plates[last*PLATES + fill[last]] = rq.value;
            fill[last]++;
            total++;
          end
        end
        sps_pkg::KIND_POP: begin
          while (open_cnt > 0 && fill[open_cnt-1] == 0) open_cnt--;
          if (open_cnt == 0) begin
            r.status = sps_pkg::ST_EMPTY;
          end else begin
            r.popped = take_top(open_cnt - 1);
            if (fill[open_cnt-1] == 0) open_cnt--;
          end
        end
        sps_pkg::KIND_POP_AT: begin
          if (rq.idx >= open_cnt) begin
            r.status = sps_pkg::ST_BAD_INDEX;
          end else if (fill[rq.idx] == 0) begin
            r.status = sps_pkg::ST_EMPTY;
          end else begin
            r.popped = take_top(rq.idx);
          end
        end
        default: begin
        end
      endcase
      r.in_use = open_cnt[sps_pkg::INUSE_W-1:0];
      r.total  = total[sps_pkg::TOTAL_W-1:0];
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void check_result(stack_result_t got);
      stack_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request outstanding: %h", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.popped !== want.popped) begin
        $display("%0t: popped_value expected %h actual %h", $time, want.popped, got.popped);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.in_use !== want.in_use) begin
        $display("%0t: stacks_in_use expected %0d actual %0d", $time, want.in_use,
                 got.in_use);
        errors++;
      end
      if (got.total !== want.total) begin
        $display("%0t: total_plates expected %0d actual %0d", $time, want.total, got.total);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sps_req_if req ();
  sps_rsp_if rsp ();

  segmented_plate_stack u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  plate_scoreboard sb = new();
  bit              send_quiet;
  bit              rsp_quiet;

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_delay(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [sps_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic plate_request_t random_request(traffic_mode_e mode);
    plate_request_t rq;
    int unsigned    r;
    int unsigned    p_push;
    int unsigned    p_pop;
    int unsigned    p_pop_at;
    case (mode)
      MODE_FILL:  begin p_push = 85; p_pop = 93; p_pop_at = 98; end
      MODE_DRAIN: begin p_push = 15; p_pop = 60; p_pop_at = 95; end
      default:    begin p_push = 45; p_pop = 70; p_pop_at = 95; end
    endcase
    rq.value = pick_value();
    rq.idx   = $urandom_range(15);
    r = $urandom_range(99);
    if (r < p_push)        rq.kind = sps_pkg::KIND_PUSH;
    else if (r < p_pop)    rq.kind = sps_pkg::KIND_POP;
    else if (r < p_pop_at) rq.kind = sps_pkg::KIND_POP_AT;
    else                   rq.kind = KIND_UNUSED;
    // Most pop-at requests name an open substack so that they do real work.
    if (rq.kind == sps_pkg::KIND_POP_AT && sb.open_cnt > 0 && $urandom_range(99) < 80)
      rq.idx = $urandom_range(sb.open_cnt - 1);
    return rq;
  endfunction

  task automatic send_request(plate_request_t rq, int unsigned gap);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.kind        <= rq.kind;
    req.push_value  <= rq.value;
    req.stack_index <= rq.idx;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(rq);
  endtask

  task automatic send_fields(logic [sps_pkg::KIND_W-1:0] kind,
                             logic [sps_pkg::VALUE_W-1:0] value,
                             logic [sps_pkg::INDEX_W-1:0] idx);
    plate_request_t rq;
    rq.kind  = kind;
    rq.value = value;
    rq.idx   = idx;
    send_request(rq, pick_delay(send_quiet));
  endtask

  // Holds the request channel low until every outstanding result has come back.
  task automatic hold_until_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: checks each accepted result and stalls at random.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp.ready  = 1'b0;
    rsp_quiet  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready)
        sb.check_result({rsp.popped_value, rsp.status, rsp.stacks_in_use, rsp.total_plates});
      if ($urandom_range(299) == 0) rsp_quiet = ~rsp_quiet;
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (!rsp_quiet && $urandom_range(99) < 25) begin
        stall_left = pick_delay(1'b0);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    traffic_mode_e mode;
    int unsigned   sent;
    int unsigned   seg_len;
    int unsigned   seg_no;
    req.valid       = 1'b0;
    req.kind        = sps_pkg::KIND_PUSH;
    req.push_value  = '0;
    req.stack_index = '0;
    send_quiet      = 1'b0;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty pops, bad indexes, the unused kind, value extremes,
    // an emptied named substack kept open and trailing empties closed by a pop.
    send_fields(sps_pkg::KIND_POP,    32'h0000_0000, 4'd0);
    send_fields(sps_pkg::KIND_POP_AT, 32'hffff_ffff, 4'd0);
    send_fields(KIND_UNUSED,          32'hffff_ffff, 4'd15);
    send_fields(sps_pkg::KIND_PUSH,   32'h8000_0000, 4'd15);
    send_fields(sps_pkg::KIND_PUSH,   32'h7fff_ffff, 4'd0);
    send_fields(sps_pkg::KIND_PUSH,   32'h0000_0000, 4'd0);
    send_fields(sps_pkg::KIND_PUSH,   32'hffff_ffff, 4'd0);
    send_fields(sps_pkg::KIND_PUSH,   32'h0000_0005, 4'd0);
    send_fields(sps_pkg::KIND_POP_AT, 32'h0000_0000, 4'd15);
    send_fields(sps_pkg::KIND_POP_AT, 32'h0000_0000, 4'd1);
    send_fields(sps_pkg::KIND_POP_AT, 32'h0000_0000, 4'd1);
    send_fields(sps_pkg::KIND_POP,    32'h0000_0000, 4'd0);
    send_fields(sps_pkg::KIND_PUSH,   32'h0000_0001, 4'd0);
    send_fields(sps_pkg::KIND_PUSH,   32'h0000_0002, 4'd0);
    send_fields(sps_pkg::KIND_POP_AT, 32'h0000_0000, 4'd0);
    send_fields(sps_pkg::KIND_POP,    32'h0000_0000, 4'd0);
    send_fields(sps_pkg::KIND_POP,    32'h0000_0000, 4'd0);
    send_fields(sps_pkg::KIND_POP,    32'h0000_0000, 4'd0);
    send_fields(sps_pkg::KIND_POP,    32'h0000_0000, 4'd0);
    send_fields(sps_pkg::KIND_POP,    32'h0000_0000, 4'd0);
    send_fields(sps_pkg::KIND_POP_AT, 32'h0000_0000, 4'd0);
    send_fields(KIND_UNUSED,          32'h0000_0000, 4'd0);

    // Random part in segments; the first fills the stacks until pushes are
    // refused, the second drains them.
    sent   = 0;
    seg_no = 0;
    while (sent < 950) begin
      if (seg_no == 0)      mode = MODE_FILL;
      else if (seg_no == 1) mode = MODE_DRAIN;
      else                  mode = traffic_mode_e'($urandom_range(2));
      send_quiet = ($urandom_range(3) == 0);
      seg_len    = (seg_no == 0) ? 110 : $urandom_range(120, 40);
      repeat (seg_len) begin
        send_request(random_request(mode), pick_delay(send_quiet));
        sent++;
      end
      if (seg_no == 0 || $urandom_range(2) == 0) hold_until_drained();
      seg_no++;
    end

    req.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== segmented_plate_stack.f =====
rtl/sps_pkg.sv
rtl/sps_req_if.sv
rtl/sps_rsp_if.sv
rtl/sps_datapath.sv
rtl/sps_controller.sv
rtl/segmented_plate_stack.sv
tb/segmented_plate_stack_tb.sv
